FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Empty bodies in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define SSE_ASSERT(lbl, clk, rst_n, prop)
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

FILE: rtl/sse_pkg.sv
package sse_pkg;

  localparam int unsigned MemAddrBitsDef = 16;
  localparam int unsigned CurAddrW       = 24;
  localparam int unsigned CountW         = 9;
  localparam int unsigned SizeW          = 5;

  // command codes
  localparam logic [7:0] CmdWrsr    = 8'h01;
  localparam logic [7:0] CmdWren    = 8'h06;
  localparam logic [7:0] CmdWrdi    = 8'h04;
  localparam logic [7:0] CmdRdsr    = 8'h05;
  localparam logic [7:0] CmdRead    = 8'h03;
  localparam logic [7:0] CmdWrite   = 8'h02;
  localparam logic [7:0] CmdReadHi  = 8'h0b;
  localparam logic [7:0] CmdWriteHi = 8'h0a;
  localparam logic [7:0] CmdRdid    = 8'h9f;

  // response bytes
  localparam logic [7:0] StatWel   = 8'h02;
  localparam logic [7:0] StatSmall = 8'hf0;
  localparam logic [7:0] IdByte    = 8'hff;

  // transfer lengths that identify the part
  localparam logic [CountW-1:0] CountMax = 9'd511;
  localparam logic [CountW-1:0] Det512   = 9'd17;
  localparam logic [CountW-1:0] Det8k    = 9'd34;
  localparam logic [CountW-1:0] Det64k   = 9'd130;
  localparam logic [CountW-1:0] Det1m    = 9'd259;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       hold;
  } sse_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       size_known;
    logic [1:0] addr_bytes;
  } sse_out_t;

endpackage

FILE: rtl/sse_if.sv
// Input word channel
interface sse_in_if;
  logic             valid;
  logic             ready;
  sse_pkg::sse_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Result word channel
interface sse_out_if;
  logic              valid;
  logic              ready;
  sse_pkg::sse_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/spi_save_eeprom.sv
// A result word passes through the pending stage (with the memory access) and then the output
//   register before it is valid at the output.
// Throughput: one word per cycle, stalled by back-pressure on the output and by the clearing sweep.
// Reset: rst_ni clears all control state at once; the save store is then swept to zero,
//   one entry per cycle over all 2**MEM_ADDR_BITS entries, during which no input word is taken.
`include "assert_macros.svh"

module spi_save_eeprom #(
  parameter int unsigned MEM_ADDR_BITS = sse_pkg::MemAddrBitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  sse_in_if.sink    in_i,
  sse_out_if.source out_o
);

  localparam int unsigned Depth = 2 ** MEM_ADDR_BITS;
  localparam int unsigned CaW   = sse_pkg::CurAddrW;
  localparam int unsigned CntW  = sse_pkg::CountW;
  localparam int unsigned SzW   = sse_pkg::SizeW;

  typedef enum logic [2:0] {
    PhIdle,
    PhWrsr,
    PhStat,
    PhAddr,
    PhRead,
    PhWrite,
    PhId
  } phase_e;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  phase_e            phase_q, phase_d;
  logic              wen_q, wen_d;            // write-enable latch (status only)
  logic              is_read_q, is_read_d;
  logic [CaW-1:0]    cur_addr_q, cur_addr_d;
  logic [CntW-1:0]   count_q, count_d;        // address + data bytes this transfer
  logic [1:0]        addr_width_q, addr_width_d;
  logic [SzW-1:0]    size_log2_q, size_log2_d;
  logic              detected_q, detected_d;
  logic [7:0]        response_q, response_d;  // SPI response register

  // Pending stage: word accepted, memory read data lands in rdata_q.
  // pend_rd  : response comes from the store
  // pend_set : response is loaded with pend_val
  // neither  : response keeps its value
  logic              pend_q, pend_d;
  logic              pend_rd_q, pend_rd_d;
  logic              pend_set_q, pend_set_d;
  logic [7:0]        pend_val_q, pend_val_d;
  logic              pend_det_q, pend_det_d;
  logic [1:0]        pend_aw_q, pend_aw_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  sse_pkg::sse_out_t out_data_q, out_data_d;

  // Post-reset clearing sweep
  logic                     clr_q, clr_d;
  logic [MEM_ADDR_BITS-1:0] clr_cnt_q, clr_cnt_d;

  // Store port
  logic [7:0]               save_mem [Depth];
  logic [7:0]               rdata_q;
  logic                     mem_we, mem_re;
  logic [MEM_ADDR_BITS-1:0] mem_addr;
  logic [7:0]               mem_wdata;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic       accept, move, in_ready;
  logic [7:0] in_byte;
  logic       in_hold;

  assign in_byte  = in_i.payload.spi_byte;
  assign in_hold  = in_i.payload.hold;
  // pending word drains into the output register when it is free or emptying
  assign move     = pend_q && (!out_valid_q || out_o.ready);
  assign in_ready = !clr_q && (!pend_q || move);
  assign accept   = in_i.valid && in_ready;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  // ---------------------------------------------------------------------------
  // Address masking: usable size is 2**min(size_log2, MEM_ADDR_BITS).
  // Larger detected sizes alias onto the store.
  // ---------------------------------------------------------------------------
  logic [MEM_ADDR_BITS-1:0] mask, idx, idx_next;
  logic [CntW-1:0]          count_inc;
  logic [7:0]               resp_new;

  always_comb begin
    for (int i = 0; i < MEM_ADDR_BITS; i++) begin
      mask[i] = (SzW'(i) < size_log2_q);
    end
  end

  assign idx       = cur_addr_q[MEM_ADDR_BITS-1:0] & mask;
  assign idx_next  = (idx + MEM_ADDR_BITS'(1)) & mask;
  assign count_inc = (count_q == sse_pkg::CountMax) ? count_q : count_q + CntW'(1);

  // response seen by the word leaving the pending stage
  assign resp_new = pend_rd_q  ? rdata_q :
                    pend_set_q ? pend_val_q : response_q;

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d      = phase_q;
    wen_d        = wen_q;
    is_read_d    = is_read_q;
    cur_addr_d   = cur_addr_q;
    count_d      = count_q;
    addr_width_d = addr_width_q;
    size_log2_d  = size_log2_q;
    detected_d   = detected_q;
    response_d   = response_q;

    pend_d     = pend_q;
    pend_rd_d  = pend_rd_q;
    pend_set_d = pend_set_q;
    pend_val_d = pend_val_q;
    pend_det_d = pend_det_q;
    pend_aw_d  = pend_aw_q;

    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;

    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = idx;
    mem_wdata = in_byte;

    // zero sweep after reset
    if (clr_q) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt_q;
      mem_wdata = 8'h00;
      clr_cnt_d = clr_cnt_q + MEM_ADDR_BITS'(1);
      if (clr_cnt_q == '1) begin
        clr_d = 1'b0;
      end
    end

    // output stage
    if (move) begin
      response_d            = resp_new;
      out_valid_d           = 1'b1;
      out_data_d.read_byte  = resp_new;
      out_data_d.size_known = pend_det_q;
      out_data_d.addr_bytes = pend_aw_q;
      pend_d                = 1'b0;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // accept stage
    if (accept) begin
      pend_rd_d  = 1'b0;
      pend_set_d = 1'b0;
      pend_val_d = 8'h00;

      case (phase_q)
        PhIdle: begin
          case (in_byte)
            sse_pkg::CmdWrsr: phase_d = PhWrsr;
            sse_pkg::CmdWren: wen_d = 1'b1;
            sse_pkg::CmdWrdi: wen_d = 1'b0;
            sse_pkg::CmdRdsr: phase_d = PhStat;
            sse_pkg::CmdRdid: phase_d = PhId;
            sse_pkg::CmdRead, sse_pkg::CmdWrite: begin
              is_read_d  = (in_byte == sse_pkg::CmdRead);
              cur_addr_d = '0;
              count_d    = '0;
              phase_d    = PhAddr;
            end
            sse_pkg::CmdReadHi, sse_pkg::CmdWriteHi: begin
              // upper half of a 1-byte-address part
              is_read_d  = (in_byte == sse_pkg::CmdReadHi);
              cur_addr_d = CaW'(addr_width_q == 2'd1);
              count_d    = '0;
              phase_d    = PhAddr;
            end
            default: ;
          endcase
        end
        PhAddr: begin
          cur_addr_d = {cur_addr_q[CaW-9:0], in_byte};
          count_d    = count_inc;
          if (count_inc == CntW'(addr_width_q)) begin
            phase_d = is_read_q ? PhRead : PhWrite;
          end
        end
        PhRead: begin
          count_d    = count_inc;
          mem_re     = 1'b1;
          pend_rd_d  = 1'b1;
          cur_addr_d = CaW'(idx_next);
        end
        PhWrite: begin
          count_d    = count_inc;
          mem_we     = 1'b1;
          cur_addr_d = CaW'(idx_next);
        end
        PhStat: begin
          pend_set_d = 1'b1;
          pend_val_d = (wen_q ? sse_pkg::StatWel : 8'h00) |
                       ((addr_width_q == 2'd1) ? sse_pkg::StatSmall : 8'h00);
        end
        PhId: begin
          pend_set_d = 1'b1;
          pend_val_d = sse_pkg::IdByte;
        end
        default: ;  // write-status: rest of transfer ignored
      endcase

      // chip select released: size detection on the first matching length
      if (!in_hold) begin
        phase_d = PhIdle;
        if (!detected_q) begin
          case (count_d)
            sse_pkg::Det512: begin
              detected_d = 1'b1; addr_width_d = 2'd1; size_log2_d = SzW'(9);
            end
            sse_pkg::Det8k: begin
              detected_d = 1'b1; addr_width_d = 2'd2; size_log2_d = SzW'(13);
            end
            sse_pkg::Det64k: begin
              detected_d = 1'b1; addr_width_d = 2'd2; size_log2_d = SzW'(16);
            end
            sse_pkg::Det1m: begin
              detected_d = 1'b1; addr_width_d = 2'd3; size_log2_d = SzW'(20);
            end
            default: ;
          endcase
        end
        count_d = '0;
      end

      pend_d     = 1'b1;
      pend_det_d = detected_d;
      pend_aw_d  = addr_width_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      wen_q        <= 1'b0;
      is_read_q    <= 1'b0;
      cur_addr_q   <= '0;
      count_q      <= '0;
      addr_width_q <= 2'd2;
      size_log2_q  <= SzW'(16);
      detected_q   <= 1'b0;
      response_q   <= 8'h00;
      pend_q       <= 1'b0;
      pend_rd_q    <= 1'b0;
      pend_set_q   <= 1'b0;
      pend_val_q   <= 8'h00;
      pend_det_q   <= 1'b0;
      pend_aw_q    <= 2'd2;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      clr_q        <= 1'b1;
      clr_cnt_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      wen_q        <= wen_d;
      is_read_q    <= is_read_d;
      cur_addr_q   <= cur_addr_d;
      count_q      <= count_d;
      addr_width_q <= addr_width_d;
      size_log2_q  <= size_log2_d;
      detected_q   <= detected_d;
      response_q   <= response_d;
      pend_q       <= pend_d;
      pend_rd_q    <= pend_rd_d;
      pend_set_q   <= pend_set_d;
      pend_val_q   <= pend_val_d;
      pend_det_q   <= pend_det_d;
      pend_aw_q    <= pend_aw_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
      clr_q        <= clr_d;
      clr_cnt_q    <= clr_cnt_d;
    end
  end

  // Save store: one port, registered read. A write followed by a read of the
  // same entry needs a release and new command in between, so no bypass.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      save_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= save_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SSE_ASSERT(a_no_take_in_clear, clk_i, rst_ni, !(clr_q && in_i.ready))
  `SSE_ASSERT_NEXT(a_move_fills_out, clk_i, rst_ni, move, out_valid_q)
  `SSE_ASSERT(a_detect_sticky, clk_i, rst_ni, !$fell(detected_q))
  `SSE_ASSERT(a_width_on_detect, clk_i, rst_ni, $stable(addr_width_q) || $rose(detected_q))

endmodule
